@@ src/riwr_pkg.sv @@
// Shared types, constants and factor tables for the Riemann invariant block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package riwr_pkg;

  // Rheology modes; the unused code behaves as elastic.
  localparam logic [1:0] MODE_ELASTIC = 2'd0;
  localparam logic [1:0] MODE_SMOOTH  = 2'd1;
  localparam logic [1:0] MODE_STEPPED = 2'd2;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Strain thresholds in Q1.30, compared with the strain magnitude.
  localparam logic [30:0] EPS_ELASTIC = 31'd107375;
  localparam logic [30:0] EPS_STEP    = 31'd134218;
  localparam logic [30:0] EPS_FLOW    = 31'd161062;
  localparam logic [30:0] EPS_HARDEN  = 31'd858994;
  localparam logic [30:0] EPS_BREAK   = 31'd1073742;

  // Band widths and the reciprocals that turn an offset into a table index.
  localparam longint D_ERFC = longint'(EPS_FLOW) - longint'(EPS_ELASTIC);
  localparam longint D_BUMP = longint'(EPS_BREAK) - longint'(EPS_HARDEN);
  localparam int XE_W = $clog2(D_ERFC);
  localparam int XB_W = $clog2(D_BUMP);
  localparam int RECIP_SHIFT = 32;
  localparam longint M_ERFC = ((64'sd1 <<< RECIP_SHIFT) * TABLE_ENTRIES) / D_ERFC;
  localparam longint M_BUMP = ((64'sd1 <<< RECIP_SHIFT) * TABLE_ENTRIES) / D_BUMP;
  localparam int ME_W = $clog2(M_ERFC + 1);
  localparam int MB_W = $clog2(M_BUMP + 1);
  localparam int PE_W = XE_W + ME_W;
  localparam int PB_W = XB_W + MB_W;
  localparam int QE_W = PE_W - RECIP_SHIFT;
  localparam int QB_W = PB_W - RECIP_SHIFT;
  localparam int CE_W = XE_W + QE_W + 1;
  localparam int CB_W = XB_W + QB_W + 1;

  // Modulus scaling: Eeff = (E * F + rnd) >> 45, with F a 46-bit factor.
  localparam int FAC_W       = 25;
  localparam int F_W         = 46;
  localparam int SCALE_SHIFT = 45;
  localparam int FAC_SHIFT   = 21;
  localparam logic [F_W-1:0] ONE_FACTOR   = F_W'(64'd1 << SCALE_SHIFT);
  localparam logic [F_W-1:0] FLOOR_FACTOR = F_W'(64'd798915 << FAC_SHIFT);
  localparam logic [F_W-1:0] RECIP3  = F_W'(((64'd1 << SCALE_SHIFT) + 64'd2) / 64'd3);
  localparam logic [F_W-1:0] RECIP10 = F_W'(((64'd1 << SCALE_SHIFT) + 64'd9) / 64'd10);
  localparam logic [F_W-1:0] RECIP30 = F_W'(((64'd1 << SCALE_SHIFT) + 64'd29) / 64'd30);

  typedef logic [FAC_W-1:0] fac_tab_t [TABLE_ENTRIES];

  typedef struct packed {
    logic               lt_elastic;
    logic               lt_step;
    logic               lt_flow;
    logic               lt_harden;
    logic               lt_break;
  } band_t;

  // Fields of an item that ride along the pipeline.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] velocity;
    logic               neg;
    logic [30:0]        ae;
    logic [23:0]        density;
    logic [31:0]        given_speed;
  } carry_t;

  typedef struct packed {
    logic signed [31:0] invariant;
    logic [31:0]        wave_speed;
    logic [39:0]        effective_modulus;
  } res_t;

  // Shift-and-subtract division, only ever evaluated while the tables are built.
  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed division that truncates towards zero.
  function automatic longint sdiv(longint a, longint b);
    longint unsigned qa;
    qa = udiv((a < 0) ? $unsigned(-a) : $unsigned(a),
              (b < 0) ? $unsigned(-b) : $unsigned(b));
    return ((a < 0) != (b < 0)) ? -$signed(qa) : $signed(qa);
  endfunction

  // Smooth-plastic factor over the erfc band, evaluated at the bin centre.
  function automatic logic [FAC_W-1:0] erfc_factor(int k);
    longint te, m, ma, t, s, n;
    longint unsigned erfq, erfc, num;
    te = longint'(TABLE_ENTRIES);
    m = 2 * longint'(k) + 1 - te;
    ma = (m < 0) ? -m : m;
    t = sdiv(3 * ma * 64'sd4294967296, te);
    s = t;
    for (n = 1; n <= 100; n++) begin
      if (t != 0) begin
        t = sdiv(t * ma, te);
        t = sdiv(t * ma, te);
        t = sdiv(-(t * 9), n);
        s = s + sdiv(t, 2 * n + 1);
      end
    end
    if (s < 0) s = 0;
    if (s > 64'sd4294967295) s = 64'sd4294967295;
    erfq = ($unsigned(s) * 64'd1211587905) >> 30;
    if (erfq > 64'd4294967296) erfq = 64'd4294967296;
    erfc = (m < 0) ? 64'd4294967296 + erfq : 64'd4294967296 - erfq;
    num = (64'd10 * erfc + 64'd4294967296 + 64'd2688) / 64'd5376;
    return FAC_W'(num);
  endfunction

  // Hardening bump factor, exp evaluated as 2^-x with a short series.
  function automatic logic [FAC_W-1:0] bump_factor(int k);
    longint m, sum;
    longint unsigned p, q, y, n, g, w, term, i, num;
    m = 2 * longint'(k) + 1 - longint'(TABLE_ENTRIES);
    p = $unsigned(m * m);
    q = $unsigned(longint'(TABLE_ENTRIES) * longint'(TABLE_ENTRIES)) - p;
    y = udiv(p * 64'd1549082005, q);
    n = y >> 30;
    g = 64'd0;
    if (n < 64'd40) begin
      w = ((y & 64'h3fffffff) * 64'd744261118) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (i = 1; i <= 16; i++) begin
        term = udiv((term * w) >> 30, i);
        if (i[0]) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      g = $unsigned(sum) >> n;
    end
    num = (64'd20 * g + 64'd3 * (64'd1 << 30) + 64'd2016) / 64'd4032;
    return FAC_W'(num);
  endfunction

  function automatic fac_tab_t erfc_table();
    fac_tab_t tab;
    for (int k = 0; k < TABLE_ENTRIES; k++) tab[k] = erfc_factor(k);
    return tab;
  endfunction

  function automatic fac_tab_t bump_table();
    fac_tab_t tab;
    for (int k = 0; k < TABLE_ENTRIES; k++) tab[k] = bump_factor(k);
    return tab;
  endfunction

  localparam fac_tab_t ERFC_TAB = erfc_table();
  localparam fac_tab_t BUMP_TAB = bump_table();

endpackage

`default_nettype wire

@@ src/riwr_in_if.sv @@
// Input channel of the Riemann invariant block: valid/ready and one node item.
// Stands alone; no package needed.
`default_nettype none

interface riwr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] velocity;
  logic signed [30:0] strain;
  logic [23:0]        density;
  logic [39:0]        base_modulus;
  logic [31:0]        given_speed;

  modport source (output valid, func, velocity, strain, density, base_modulus,
                  given_speed, input ready);
  modport sink (input valid, func, velocity, strain, density, base_modulus,
                given_speed, output ready);
endinterface

`default_nettype wire

@@ src/riwr_out_if.sv @@
// Output channel of the Riemann invariant block: valid/ready and one result item.
// Stands alone; no package needed.
`default_nettype none

interface riwr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] invariant;
  logic [31:0]        wave_speed;
  logic [39:0]        effective_modulus;

  modport source (output valid, invariant, wave_speed, effective_modulus, input ready);
  modport sink (input valid, invariant, wave_speed, effective_modulus, output ready);
endinterface

`default_nettype wire

@@ src/riwr_modulus.sv @@
// Seven-stage effective modulus pipeline: band test, table index, factor, scale.
// Depends on riwr_pkg.
`default_nettype none

module riwr_modulus (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              valid,
  input  wire riwr_pkg::carry_t  carry,
  input  wire logic [39:0]       modulus,
  input  wire logic [1:0]        mode,
  output logic                   eeff_valid,
  output riwr_pkg::carry_t       eeff_carry,
  output logic [39:0]            eeff
);

  logic v1, v2, v3, v4, v5, v6, v7;
  riwr_pkg::carry_t c1, c2, c3, c4, c5, c6, c7;
  logic [39:0] e1, e2, e3, e4, e5;
  logic [1:0] m1, m2, m3, m4;
  riwr_pkg::band_t b2, b3, b4;
  logic [riwr_pkg::XE_W-1:0] xe2, xe3;
  logic [riwr_pkg::XB_W-1:0] xb2, xb3;
  logic [riwr_pkg::PE_W-1:0] pe3;
  logic [riwr_pkg::PB_W-1:0] pb3;
  logic [riwr_pkg::IDX_W-1:0] ke4, kb4;
  logic [riwr_pkg::F_W-1:0] f5;
  logic rnd5, rnd6;
  logic [43:0] pp_hh, pp_lh;
  logic [41:0] pp_hl, pp_ll;
  logic [39:0] eeff7;

  riwr_pkg::band_t band;
  logic [riwr_pkg::QE_W-1:0] qe;
  logic [riwr_pkg::QB_W-1:0] qb;
  logic [riwr_pkg::QE_W:0] qe1, ke_full;
  logic [riwr_pkg::QB_W:0] qb1, kb_full;
  logic [riwr_pkg::CE_W-1:0] lhs_e, rhs_e;
  logic [riwr_pkg::CB_W-1:0] lhs_b, rhs_b;
  logic [riwr_pkg::IDX_W-1:0] ke, kb;
  logic [riwr_pkg::F_W-1:0] f_sel;
  logic rnd_sel;
  logic [85:0] sum;

  always_comb begin
    band.lt_elastic = c1.ae < riwr_pkg::EPS_ELASTIC;
    band.lt_step    = c1.ae < riwr_pkg::EPS_STEP;
    band.lt_flow    = c1.ae < riwr_pkg::EPS_FLOW;
    band.lt_harden  = c1.ae < riwr_pkg::EPS_HARDEN;
    band.lt_break   = c1.ae < riwr_pkg::EPS_BREAK;
  end

  // The reciprocal estimate is at most one short; one compare fixes it.
  always_comb begin
    qe = pe3[riwr_pkg::PE_W-1:riwr_pkg::RECIP_SHIFT];
    qb = pb3[riwr_pkg::PB_W-1:riwr_pkg::RECIP_SHIFT];
    qe1 = {1'b0, qe} + 1'b1;
    qb1 = {1'b0, qb} + 1'b1;
    lhs_e = riwr_pkg::CE_W'(qe1) * riwr_pkg::CE_W'(riwr_pkg::D_ERFC);
    rhs_e = riwr_pkg::CE_W'(xe3) * riwr_pkg::CE_W'(riwr_pkg::TABLE_ENTRIES);
    lhs_b = riwr_pkg::CB_W'(qb1) * riwr_pkg::CB_W'(riwr_pkg::D_BUMP);
    rhs_b = riwr_pkg::CB_W'(xb3) * riwr_pkg::CB_W'(riwr_pkg::TABLE_ENTRIES);
    ke_full = (lhs_e <= rhs_e) ? qe1 : {1'b0, qe};
    kb_full = (lhs_b <= rhs_b) ? qb1 : {1'b0, qb};
    ke = (ke_full > (riwr_pkg::QE_W + 1)'(riwr_pkg::TABLE_ENTRIES - 1)) ?
         riwr_pkg::IDX_W'(riwr_pkg::TABLE_ENTRIES - 1) : ke_full[riwr_pkg::IDX_W-1:0];
    kb = (kb_full > (riwr_pkg::QB_W + 1)'(riwr_pkg::TABLE_ENTRIES - 1)) ?
         riwr_pkg::IDX_W'(riwr_pkg::TABLE_ENTRIES - 1) : kb_full[riwr_pkg::IDX_W-1:0];
  end

  always_comb begin
    f_sel = riwr_pkg::ONE_FACTOR;
    rnd_sel = 1'b0;
    case (m4)
      riwr_pkg::MODE_SMOOTH: begin
        if (!b4.lt_elastic) begin
          rnd_sel = 1'b1;
          if (b4.lt_flow) begin
            f_sel = riwr_pkg::F_W'(riwr_pkg::ERFC_TAB[ke4]) << riwr_pkg::FAC_SHIFT;
          end else if (b4.lt_harden) begin
            f_sel = riwr_pkg::FLOOR_FACTOR;
          end else if (b4.lt_break) begin
            f_sel = riwr_pkg::F_W'(riwr_pkg::BUMP_TAB[kb4]) << riwr_pkg::FAC_SHIFT;
          end else begin
            f_sel = riwr_pkg::FLOOR_FACTOR;
          end
        end
      end
      riwr_pkg::MODE_STEPPED: begin
        if (b4.lt_elastic) f_sel = riwr_pkg::ONE_FACTOR;
        else if (b4.lt_step) f_sel = riwr_pkg::RECIP3;
        else if (b4.lt_flow) f_sel = riwr_pkg::RECIP10;
        else f_sel = riwr_pkg::RECIP30;
      end
      default: ;
    endcase
  end

  always_comb begin
    sum = {pp_hh, 42'b0}
        + (86'(pp_hl) << 20)
        + (86'(pp_lh) << 22)
        + 86'(pp_ll)
        + (86'(rnd6) << (riwr_pkg::SCALE_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= carry; e1 <= modulus; m1 <= mode;

      c2 <= c1; e2 <= e1; m2 <= m1; b2 <= band;
      xe2 <= riwr_pkg::XE_W'(c1.ae - riwr_pkg::EPS_ELASTIC);
      xb2 <= riwr_pkg::XB_W'(c1.ae - riwr_pkg::EPS_HARDEN);

      c3 <= c2; e3 <= e2; m3 <= m2; b3 <= b2; xe3 <= xe2; xb3 <= xb2;
      pe3 <= riwr_pkg::PE_W'(xe2) * riwr_pkg::PE_W'(riwr_pkg::M_ERFC);
      pb3 <= riwr_pkg::PB_W'(xb2) * riwr_pkg::PB_W'(riwr_pkg::M_BUMP);

      c4 <= c3; e4 <= e3; m4 <= m3; b4 <= b3; ke4 <= ke; kb4 <= kb;

      c5 <= c4; e5 <= e4; f5 <= f_sel; rnd5 <= rnd_sel;

      c6 <= c5; rnd6 <= rnd5;
      pp_hh <= 44'(e5[39:20]) * 44'(f5[45:22]);
      pp_hl <= 42'(e5[39:20]) * 42'(f5[21:0]);
      pp_lh <= 44'(e5[19:0]) * 44'(f5[45:22]);
      pp_ll <= 42'(e5[19:0]) * 42'(f5[21:0]);

      c7 <= c6; eeff7 <= sum[84:45];
    end
  end

  assign eeff_valid = v7;
  assign eeff_carry = c7;
  assign eeff       = eeff7;

endmodule

`default_nettype wire

@@ src/riwr_speed.sv @@
// Wave speed pipeline: 64 stages of long division of Eeff*2^40 by density,
// then 32 stages of digit-by-digit square root. Depends on riwr_pkg.
`default_nettype none

module riwr_speed (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              valid,
  input  wire riwr_pkg::carry_t  carry,
  input  wire logic [39:0]       eeff,
  output logic                   root_valid,
  output riwr_pkg::carry_t       root_carry,
  output logic [39:0]            root_eeff,
  output logic [31:0]            root,
  output logic                   sat
);

  typedef struct packed {
    riwr_pkg::carry_t c;
    logic [39:0]      eeff;
    logic             sat;
    logic [23:0]      rem;
    logic [63:0]      quo;
  } div_t;

  typedef struct packed {
    riwr_pkg::carry_t c;
    logic [39:0]      eeff;
    logic             sat;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [63:0]      rad;
  } sq_t;

  logic dvld [0:64];
  div_t dst  [0:64];
  logic svld [1:32];
  sq_t  sst  [1:32];
  sq_t  head;

  // A quotient of 2^64 or more saturates the speed; zero density lands here too.
  always_ff @(posedge clk) begin
    if (rst) dvld[0] <= 1'b0;
    else if (en) dvld[0] <= valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst[0].c    <= carry;
      dst[0].eeff <= eeff;
      dst[0].sat  <= 24'(eeff[39:24]) >= carry.density;
      dst[0].rem  <= 24'(eeff[39:24]);
      dst[0].quo  <= '0;
    end
  end

  for (genvar g = 1; g <= 64; g++) begin : g_div
    logic nb;
    logic [24:0] sh;
    logic [25:0] diff;
    logic take;

    if (64 - g >= 40) begin : g_num
      assign nb = dst[g-1].eeff[24-g];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign sh   = {dst[g-1].rem, nb};
    assign diff = {1'b0, sh} - {2'b0, dst[g-1].c.density};
    assign take = !diff[25];

    always_ff @(posedge clk) begin
      if (rst) dvld[g] <= 1'b0;
      else if (en) dvld[g] <= dvld[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst[g].c    <= dst[g-1].c;
        dst[g].eeff <= dst[g-1].eeff;
        dst[g].sat  <= dst[g-1].sat;
        dst[g].rem  <= take ? diff[23:0] : sh[23:0];
        dst[g].quo  <= {dst[g-1].quo[62:0], take};
      end
    end
  end

  always_comb begin
    head.c    = dst[64].c;
    head.eeff = dst[64].eeff;
    head.sat  = dst[64].sat;
    head.rem  = '0;
    head.root = '0;
    head.rad  = dst[64].quo;
  end

  for (genvar j = 1; j <= 32; j++) begin : g_sqrt
    sq_t prev;
    logic prev_v;
    logic [35:0] sh;
    logic [35:0] trial;
    logic [36:0] diff;
    logic take;

    if (j == 1) begin : g_first
      assign prev   = head;
      assign prev_v = dvld[64];
    end else begin : g_next
      assign prev   = sst[j-1];
      assign prev_v = svld[j-1];
    end

    assign sh    = {prev.rem, prev.rad[63:62]};
    assign trial = {2'b0, prev.root, 2'b01};
    assign diff  = {1'b0, sh} - {1'b0, trial};
    assign take  = !diff[36];

    always_ff @(posedge clk) begin
      if (rst) svld[j] <= 1'b0;
      else if (en) svld[j] <= prev_v;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sst[j].c    <= prev.c;
        sst[j].eeff <= prev.eeff;
        sst[j].sat  <= prev.sat;
        sst[j].rem  <= take ? diff[33:0] : sh[33:0];
        sst[j].root <= {prev.root[30:0], take};
        sst[j].rad  <= {prev.rad[61:0], 2'b00};
      end
    end
  end

  assign root_valid = svld[32];
  assign root_carry = sst[32].c;
  assign root_eeff  = sst[32].eeff;
  assign root       = sst[32].root;
  assign sat        = sst[32].sat;

endmodule

`default_nettype wire

@@ src/riwr_invariant.sv @@
// Final two stages: speed selection and a*eps product, then rounding,
// signed sum and saturation into a result item. Depends on riwr_pkg.
`default_nettype none

module riwr_invariant (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              valid,
  input  wire riwr_pkg::carry_t  carry,
  input  wire logic [39:0]       eeff,
  input  wire logic [31:0]       root,
  input  wire logic              sat,
  output logic                   res_valid,
  output riwr_pkg::res_t         res
);

  logic v1, v2;
  riwr_pkg::carry_t c1;
  logic [39:0] e1;
  logic [31:0] sp1;
  logic [62:0] prod1;
  riwr_pkg::res_t res2;

  logic [31:0] speed;
  logic [62:0] rounded;
  logic [32:0] mag;
  logic signed [34:0] vx, vsel, msel, total;
  logic signed [31:0] clipped;

  always_comb begin
    if (carry.func[1]) speed = carry.given_speed;
    else if (sat) speed = '1;
    else speed = root;
  end

  // Halves round away from zero: the magnitude is rounded before the sign.
  always_comb begin
    rounded = prod1 + (63'd1 << 29);
    mag = rounded[62:30];
    vx = {{3{c1.velocity[31]}}, c1.velocity};
    vsel = c1.func[0] ? vx : -vx;
    msel = c1.neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    total = vsel + msel;
    if (total > 35'sd2147483647) clipped = 32'sh7fffffff;
    else if (total < -35'sd2147483648) clipped = 32'sh80000000;
    else clipped = total[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= carry;
      e1 <= eeff;
      sp1 <= speed;
      prod1 <= 63'(speed) * 63'(carry.ae);
      res2.invariant <= clipped;
      res2.wave_speed <= sp1;
      res2.effective_modulus <= e1;
    end
  end

  assign res_valid = v2;
  assign res       = res2;

endmodule

`default_nettype wire

@@ src/riemann_invariant_with_rheology.sv @@
// Riemann invariant with strain-dependent rheology. One grid node item enters per
// cycle while the skid register is empty. Its result passes through the effective
// modulus stages, then the wave speed stages (one quotient bit per stage over 64
// stages of long division, then one root bit per stage over 32 square-root stages),
// then the invariant stages and the output register. The whole pipeline advances
// together; a stalled result is parked in a one-item skid register, and input is
// refused only while that register is occupied. The rheology mode is written through
// cfg_wr_en/cfg_wr_data and should only change while no item is in flight.
// Depends on riwr_pkg, riwr_in_if, riwr_out_if and the three riwr_ stage modules.
`default_nettype none

module riemann_invariant_with_rheology (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  riwr_in_if.sink    item_in,
  riwr_out_if.source item_out
);

  logic [1:0] mode;
  logic en;
  riwr_pkg::carry_t in_carry;

  logic mod_valid;
  riwr_pkg::carry_t mod_carry;
  logic [39:0] mod_eeff;

  logic spd_valid;
  riwr_pkg::carry_t spd_carry;
  logic [39:0] spd_eeff;
  logic [31:0] spd_root;
  logic spd_sat;

  logic inv_valid;
  riwr_pkg::res_t inv_res;

  logic out_valid, skid_valid;
  riwr_pkg::res_t out_res, skid_res;
  logic push, pop;

  always_ff @(posedge clk) begin
    if (rst) mode <= riwr_pkg::MODE_ELASTIC;
    else if (cfg_wr_en) mode <= cfg_wr_data;
  end

  assign en = !skid_valid;
  assign item_in.ready = en;

  always_comb begin
    in_carry.func        = item_in.func;
    in_carry.velocity    = item_in.velocity;
    in_carry.neg         = item_in.strain[30];
    in_carry.ae          = item_in.strain[30] ? 31'(-item_in.strain) : item_in.strain;
    in_carry.density     = item_in.density;
    in_carry.given_speed = item_in.given_speed;
  end

  riwr_modulus u_modulus (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (item_in.valid),
    .carry      (in_carry),
    .modulus    (item_in.base_modulus),
    .mode       (mode),
    .eeff_valid (mod_valid),
    .eeff_carry (mod_carry),
    .eeff       (mod_eeff)
  );

  riwr_speed u_speed (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (mod_valid),
    .carry      (mod_carry),
    .eeff       (mod_eeff),
    .root_valid (spd_valid),
    .root_carry (spd_carry),
    .root_eeff  (spd_eeff),
    .root       (spd_root),
    .sat        (spd_sat)
  );

  riwr_invariant u_invariant (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (spd_valid),
    .carry     (spd_carry),
    .eeff      (spd_eeff),
    .root      (spd_root),
    .sat       (spd_sat),
    .res_valid (inv_valid),
    .res       (inv_res)
  );

  assign push = en && inv_valid;
  assign pop  = out_valid && item_out.ready;

  // An item leaving the pipeline while the output is held goes to the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res   <= inv_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= inv_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign item_out.valid             = out_valid;
  assign item_out.invariant         = out_res.invariant;
  assign item_out.wave_speed        = out_res.wave_speed;
  assign item_out.effective_modulus = out_res.effective_modulus;

endmodule

`default_nettype wire

@@ dv/tb_riemann_invariant_with_rheology.sv @@
// Self-checking testbench for riemann_invariant_with_rheology: random node items in
// every mode, directed ones in smooth and stepped, all checked against an in-bench
// predictor. Depends on riwr_pkg, riwr_in_if, riwr_out_if and the block itself.
`default_nettype none

module tb_riemann_invariant_with_rheology;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint unsigned SMOOTH_FLOOR = 64'd798915;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] velocity;
    logic signed [30:0] strain;
    logic [23:0]        density;
    logic [39:0]        base_modulus;
    logic [31:0]        given_speed;
  } node_t;

  // Keeps the predicted results of accepted nodes in arrival order.
  class invariant_scoreboard;
    longint unsigned erfc_fac[riwr_pkg::TABLE_ENTRIES];
    longint unsigned bump_fac[riwr_pkg::TABLE_ENTRIES];
    logic [1:0] mode;
    riwr_pkg::res_t pending_results[$];
    int errors;
    int checked;

    function new();
      for (int k = 0; k < riwr_pkg::TABLE_ENTRIES; k++) begin
        erfc_fac[k] = erfc_point(k);
        bump_fac[k] = bump_point(k);
      end
      mode = riwr_pkg::MODE_ELASTIC;
      errors = 0;
      checked = 0;
    endfunction

    // erf by its power series in Q32, then (0.05 + erfc/2) / 1.05 in Q0.24.
    function longint unsigned erfc_point(int k);
      longint te, m, ma, t, s, n;
      longint unsigned erfq, ec;
      te = riwr_pkg::TABLE_ENTRIES;
      m = 2 * longint'(k) + 1 - te;
      ma = (m < 0) ? -m : m;
      t = (3 * ma * 64'sd4294967296) / te;
      s = t;
      n = 1;
      while (n <= 100 && t != 0) begin
        t = (t * ma) / te;
        t = (t * ma) / te;
        t = (-(t * 9)) / n;
        s = s + t / (2 * n + 1);
        n++;
      end
      if (s < 0) s = 0;
      if (s > 64'sd4294967295) s = 64'sd4294967295;
      erfq = (unsigned'(s) * 64'd1211587905) >> 30;
      if (erfq > 64'd4294967296) erfq = 64'd4294967296;
      ec = (m < 0) ? 64'd4294967296 + erfq : 64'd4294967296 - erfq;
      return (64'd10 * ec + 64'd4294967296 + 64'd2688) / 64'd5376;
    endfunction

    // exp(-u^2/(1-u^2)) as 2^-y, the fraction through a 16-term series.
    function longint unsigned bump_point(int k);
      longint m, acc;
      longint unsigned p, q, y, sh, g, w, term;
      m = 2 * longint'(k) + 1 - longint'(riwr_pkg::TABLE_ENTRIES);
      p = unsigned'(m * m);
      q = unsigned'(longint'(riwr_pkg::TABLE_ENTRIES) * riwr_pkg::TABLE_ENTRIES) - p;
      y = (p * 64'd1549082005) / q;
      sh = y >> 30;
      g = 0;
      if (sh < 40) begin
        w = ((y & 64'h3fffffff) * 64'd744261118) >> 30;
        term = 64'd1 << 30;
        acc = 64'sd1 <<< 30;
        for (longint unsigned i = 1; i <= 16; i++) begin
          term = ((term * w) >> 30) / i;
          if (i[0]) acc = acc - signed'(term);
          else acc = acc + signed'(term);
        end
        if (acc < 0) acc = 0;
        g = unsigned'(acc) >> sh;
      end
      return (64'd20 * g + 64'd3 * (64'd1 << 30) + 64'd2016) / 64'd4032;
    endfunction

    function longint unsigned bin_of(longint unsigned ae, longint unsigned lo,
                                     longint unsigned hi);
      longint unsigned k;
      k = (ae - lo) * riwr_pkg::TABLE_ENTRIES / (hi - lo);
      if (k >= riwr_pkg::TABLE_ENTRIES) k = riwr_pkg::TABLE_ENTRIES - 1;
      return k;
    endfunction

    function longint unsigned scaled(longint unsigned e, longint unsigned f);
      return (e * f + (64'd1 << 23)) >> 24;
    endfunction

    function longint unsigned modulus_after_rheology(longint unsigned e,
                                                     longint unsigned ae);
      case (mode)
        riwr_pkg::MODE_SMOOTH: begin
          if (ae < riwr_pkg::EPS_ELASTIC) return e;
          if (ae < riwr_pkg::EPS_FLOW)
            return scaled(e, erfc_fac[bin_of(ae, riwr_pkg::EPS_ELASTIC, riwr_pkg::EPS_FLOW)]);
          if (ae < riwr_pkg::EPS_HARDEN) return scaled(e, SMOOTH_FLOOR);
          if (ae < riwr_pkg::EPS_BREAK)
            return scaled(e, bump_fac[bin_of(ae, riwr_pkg::EPS_HARDEN, riwr_pkg::EPS_BREAK)]);
          return scaled(e, SMOOTH_FLOOR);
        end
        riwr_pkg::MODE_STEPPED: begin
          if (ae < riwr_pkg::EPS_ELASTIC) return e;
          if (ae < riwr_pkg::EPS_STEP) return e / 3;
          if (ae < riwr_pkg::EPS_FLOW) return e / 10;
          return e / 30;
        end
        default: return e;
      endcase
    endfunction

    // Largest 32-bit s with s*s*rho <= Eeff * 2^40, bit by bit.
    function longint unsigned wave_root(longint unsigned eeff, logic [23:0] rho);
      logic [127:0] lim, s, t;
      lim = {88'd0, eeff[39:0]} << 40;
      s = 0;
      for (int b = 31; b >= 0; b--) begin
        t = s | (128'd1 << b);
        if (t * t * rho <= lim) s = t;
      end
      return s[63:0];
    endfunction

    function riwr_pkg::res_t predict(node_t n);
      longint eps, v, r;
      longint unsigned ae, eeff, spd, mag;
      riwr_pkg::res_t res;
      eps = n.strain;
      v = n.velocity;
      ae = unsigned'(eps < 0 ? -eps : eps);
      eeff = modulus_after_rheology(n.base_modulus, ae);
      spd = n.func[1] ? longint'(n.given_speed) : wave_root(eeff, n.density);
      mag = (spd * ae + (64'd1 << 29)) >> 30;
      r = (n.func[0] ? v : -v) + (eps < 0 ? -signed'(mag) : signed'(mag));
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.invariant = r[31:0];
      res.wave_speed = spd[31:0];
      res.effective_modulus = eeff[39:0];
      return res;
    endfunction

    function void note_node(node_t n);
      pending_results.push_back(predict(n));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(riwr_pkg::res_t got);
      riwr_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result, invariant", got.invariant, 0);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.invariant !== want.invariant)
        report("invariant", got.invariant, want.invariant);
      if (got.wave_speed !== want.wave_speed)
        report("wave_speed", got.wave_speed, want.wave_speed);
      if (got.effective_modulus !== want.effective_modulus)
        report("effective_modulus", got.effective_modulus, want.effective_modulus);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = riwr_pkg::MODE_ELASTIC;
  bit         quiet = 1'b0;
  bit         hold_request = 1'b0;
  int         sent = 0;

  riwr_in_if  in_ch();
  riwr_out_if out_ch();

  riemann_invariant_with_rheology dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_in     (in_ch),
    .item_out    (out_ch)
  );

  invariant_scoreboard sb = new();

  always #2 clk = ~clk;

  initial begin
    #800000;
    $display("riemann_invariant_with_rheology test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = RX_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    riwr_pkg::res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.invariant = out_ch.invariant;
      got.wave_speed = out_ch.wave_speed;
      got.effective_modulus = out_ch.effective_modulus;
      sb.check_result(got);
    end
  end

  // Unless quiet, each cycle before an item is offered idles with chance 12 in 100.
  task send_node(node_t n);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= n.func;
    in_ch.velocity <= n.velocity;
    in_ch.strain <= n.strain;
    in_ch.density <= n.density;
    in_ch.base_modulus <= n.base_modulus;
    in_ch.given_speed <= n.given_speed;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_node(n);
    sent++;
  endtask

  // Strain magnitudes cluster on the band edges and inside each band.
  function automatic logic signed [30:0] pick_strain();
    longint unsigned ae;
    logic [30:0] edges [5];
    edges = '{riwr_pkg::EPS_ELASTIC, riwr_pkg::EPS_STEP, riwr_pkg::EPS_FLOW,
              riwr_pkg::EPS_HARDEN, riwr_pkg::EPS_BREAK};
    case ($urandom_range(0, 7))
      0: ae = $urandom_range(0, riwr_pkg::EPS_ELASTIC - 1);
      1: ae = $urandom_range(riwr_pkg::EPS_ELASTIC, riwr_pkg::EPS_FLOW - 1);
      2: ae = $urandom_range(riwr_pkg::EPS_FLOW, riwr_pkg::EPS_HARDEN - 1);
      3: ae = $urandom_range(riwr_pkg::EPS_HARDEN, riwr_pkg::EPS_BREAK - 1);
      4: ae = $urandom_range(riwr_pkg::EPS_BREAK, 32'd1 << 30);
      5: ae = edges[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2;
      default: return 31'($urandom);
    endcase
    return $urandom_range(0, 1) ? -signed'(31'(ae)) : signed'(31'(ae));
  endfunction

  function automatic node_t random_node();
    node_t n;
    n.func = 2'($urandom_range(0, 3));
    n.velocity = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h3ffff) - 32'h1ffff;
    n.strain = pick_strain();
    n.density = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 255)) :
                24'($urandom_range(1, 24'hffffff));
    n.base_modulus = ($urandom_range(0, 3) == 0) ? 40'($urandom) : 40'({$urandom, $urandom});
    n.given_speed = $urandom;
    return n;
  endfunction

  task write_mode(logic [1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mode = m;
    @(posedge clk);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task run_random(int count);
    for (int i = 0; i < count; i++) send_node(random_node());
  endtask

  task run_directed();
    node_t n;
    logic signed [30:0] strains [6];
    strains = '{31'sh3fffffff, -31'sh40000000, 31'sd0, signed'(riwr_pkg::EPS_ELASTIC),
                -signed'(riwr_pkg::EPS_HARDEN), signed'(riwr_pkg::EPS_BREAK - 31'd1)};
    for (int i = 0; i < 20; i++) begin
      n.func = i[1:0];
      n.velocity = i[2] ? 32'sh7fffffff : -32'sh80000000;
      n.strain = strains[i % 6];
      n.density = (i % 5 == 0) ? 24'd0 : (i % 5 == 1) ? 24'd1 : 24'hffffff;
      n.base_modulus = i[3] ? 40'hff_ffff_ffff : (i % 3 == 0) ? 40'd0 : 40'd70_000_000_000;
      n.given_speed = i[0] ? 32'hffffffff : 32'd0;
      send_node(n);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.velocity = '0;
    in_ch.strain = '0;
    in_ch.density = '0;
    in_ch.base_modulus = '0;
    in_ch.given_speed = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(riwr_pkg::MODE_ELASTIC);
    run_random(250);
    drain();

    write_mode(riwr_pkg::MODE_SMOOTH);
    run_directed();
    quiet = 1'b1;
    run_random(150);
    quiet = 1'b0;
    hold_request = 1'b1;
    run_random(250);
    drain();

    write_mode(riwr_pkg::MODE_STEPPED);
    run_directed();
    run_random(380);
    drain();

    write_mode(MODE_UNUSED);
    run_random(200);
    drain();

    write_mode(riwr_pkg::MODE_SMOOTH);
    run_random(300);
    drain();

    write_mode(riwr_pkg::MODE_STEPPED);
    run_random(200);
    drain();

    $display("covered %0d node items (%0d results checked) under elastic, smooth,",
             sent, sb.checked);
    $display("stepped and unused rheology modes, with random stalls and a long output hold-off");
    if (sb.errors == 0) begin
      $display("riemann_invariant_with_rheology test passed");
    end else begin
      $display("riemann_invariant_with_rheology test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
